>>> hw/rtl/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants for the multiway sorted merge block.
// ----------------------------------------------------------------------------
package msm_pkg;

   localparam int VAL_W       = 32;   // element width
   localparam int KIND_W      = 1;
   localparam int RUN_FIELD_W = 2;    // width of the run field on the request
   localparam int STATUS_W    = 2;

   localparam int RUNS_DEF  = 4;
   localparam int DEPTH_DEF = 8;

   localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH = 1'b0;
   localparam logic [KIND_W-1:0] KIND_END  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_ORDERED  = 2'd0;
   localparam logic [STATUS_W-1:0] STS_DISORDER = 2'd1;
   localparam logic [STATUS_W-1:0] STS_DROPPED  = 2'd2;
   localparam logic [STATUS_W-1:0] STS_DONE     = 2'd3;

endpackage

>>> hw/rtl/msm_ram.sv
// ----------------------------------------------------------------------------
// msm_ram
// Run buffer storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msm_ram import msm_pkg::*; #(
   parameter int WORDS = RUNS_DEF * DEPTH_DEF,
   parameter int AW    = $clog2(WORDS)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [VAL_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] mem_ff [WORDS];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/multiway_sorted_merge.sv
// ----------------------------------------------------------------------------
// multiway_sorted_merge
// K-way merge of sorted runs of signed 32-bit values into one ascending stream.
// ----------------------------------------------------------------------------
// Each request either pushes a value into the FIFO of one run (DEPTH entries
// per run) or marks that run ended. After each request the block emits the
// smallest head for as long as every run that has not ended holds an element;
// a value below the previously emitted one comes out with status 1, a push to
// a full or ended run is dropped with status 2, and once every run has ended
// and drained a status 3 response closes the merge and all state starts
// fresh. rsp_tlast marks the final response caused by a request. Requests to
// a run index not below RUNS are ignored. A push or end mark is taken in the
// idle state and then examined in the check state; each emitted element is
// chosen by one shared comparator that walks the run heads one per cycle
// through the single read port of the run buffer RAM. req_tready is
// high only while the sequencer is idle and the response register can take
// a new response.
// ----------------------------------------------------------------------------
module multiway_sorted_merge import msm_pkg::*; #(
   parameter int RUNS  = RUNS_DEF,
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VAL_W-1:0]    req_tdata,   // [31:0] value
   input  logic [2:0]          req_tuser,   // [0] kind, [2:1] run
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [VAL_W-1:0]    rsp_tdata,   // [31:0] value_res
   output logic [STATUS_W-1:0] rsp_tuser,   // [1:0] status
   output logic                rsp_tlast
);

   localparam int RUN_W = $clog2(RUNS);
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = $clog2(RUNS + 1);
   localparam int WORDS = RUNS * DEPTH;
   localparam int AW    = $clog2(WORDS);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_CHECK = 3'd1;  // decide: scan, finish or idle
   localparam logic [2:0] ST_SCAN  = 3'd2;  // walk heads through the comparator
   localparam logic [2:0] ST_EMIT  = 3'd3;  // send the winner, pop its run
   localparam logic [2:0] ST_FIN   = 3'd4;  // send completion, clear state

   logic [2:0]                     state_ff, state_in;
   logic [KIND_W-1:0]              kind_ff, kind_in;
   logic [RUNS-1:0][CW-1:0]        cnt_ff, cnt_in;
   logic [RUNS-1:0][PW-1:0]        rptr_ff, rptr_in;
   logic [RUNS-1:0]                ended_ff, ended_in;
   logic [VAL_W-1:0]               prev_ff, prev_in;
   logic [SW-1:0]                  scan_ff, scan_in;
   logic                           best_found_ff, best_found_in;
   logic [RUN_W-1:0]               best_idx_ff, best_idx_in;
   logic [VAL_W-1:0]               best_val_ff, best_val_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]               rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]            rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   // request fields
   logic [KIND_W-1:0]      req_kind;
   logic [RUN_FIELD_W-1:0] req_run;
   logic [RUN_W-1:0]       ridx;
   logic                   run_ok;
   logic                   req_fire;
   logic                   out_free;

   // buffer RAM ports
   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [VAL_W-1:0] rd_data;

   // run status summaries
   logic [RUNS-1:0] has_elem, has_post;
   logic            may_emit, all_done, more_post, fin_post;

   logic [PW:0]      slot_sum;
   logic [PW-1:0]    slot;
   logic [RUN_W-1:0] rd_idx, cmp_idx;

   assign req_kind = req_tuser[0];
   assign req_run  = req_tuser[2:1];
   assign ridx     = RUN_W'(req_run);
   assign run_ok   = 32'(req_run) < 32'(RUNS);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   // head availability now, and after popping the current winner
   always_comb begin
      for (int i = 0; i < RUNS; i++) begin
         has_elem[i] = cnt_ff[i] != '0;
         has_post[i] = (cnt_ff[i] > CW'(1)) ||
                       (has_elem[i] && (RUN_W'(i) != best_idx_ff));
      end
   end

   assign may_emit  = (|has_elem) && (&(has_elem | ended_ff));
   assign all_done  = &(ended_ff & ~has_elem);
   assign more_post = (|has_post) && (&(has_post | ended_ff));
   assign fin_post  = (kind_ff == KIND_END) && (&(ended_ff & ~has_post));

   // tail slot of the addressed run: (rptr + cnt) mod DEPTH, sum < 2*DEPTH
   assign slot_sum = (PW + 1)'(rptr_ff[ridx]) + (PW + 1)'(cnt_ff[ridx]);
   assign slot     = (slot_sum >= (PW + 1)'(DEPTH)) ?
                     PW'(slot_sum - (PW + 1)'(DEPTH)) : PW'(slot_sum);

   assign rd_idx  = RUN_W'(scan_ff);
   assign cmp_idx = RUN_W'(scan_ff - SW'(1));

   assign wr_addr = AW'(AW'(ridx) * AW'(DEPTH)) + AW'(slot);
   assign rd_addr = AW'(AW'(rd_idx) * AW'(DEPTH)) + AW'(rptr_ff[rd_idx]);
   assign rd_en   = (state_ff == ST_SCAN) && (scan_ff < SW'(RUNS));

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      rptr_in       = rptr_ff;
      ended_in      = ended_ff;
      prev_in       = prev_ff;
      scan_in       = scan_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && run_ok) begin
               kind_in = req_kind;
               if (req_kind == KIND_PUSH) begin
                  if (ended_ff[ridx] || (cnt_ff[ridx] == CW'(DEPTH))) begin
                     // drop: lone response, merge state untouched
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = STS_DROPPED;
                     rsp_last_in   = 1'b1;
                  end else begin
                     wr_en        = 1'b1;
                     cnt_in[ridx] = cnt_ff[ridx] + CW'(1);
                     state_in     = ST_CHECK;
                  end
               end else begin
                  ended_in[ridx] = 1'b1;
                  state_in       = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (may_emit) begin
               scan_in       = '0;
               best_found_in = 1'b0;
               state_in      = ST_SCAN;
            end else if ((kind_ff == KIND_END) && all_done) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // read data for run scan-1 arrives this cycle
            if (scan_ff != '0) begin
               if (cnt_ff[cmp_idx] != '0 &&
                   (!best_found_ff || ($signed(rd_data) < $signed(best_val_ff)))) begin
                  best_found_in = 1'b1;
                  best_idx_in   = cmp_idx;
                  best_val_in   = rd_data;
               end
            end
            if (scan_ff == SW'(RUNS)) begin
               state_in = ST_EMIT;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = best_val_ff;
               rsp_status_in = ($signed(best_val_ff) < $signed(prev_ff)) ?
                               STS_DISORDER : STS_ORDERED;
               rsp_last_in   = !(more_post || fin_post);
               prev_in       = best_val_ff;
               rptr_in[best_idx_ff] = (rptr_ff[best_idx_ff] == PW'(DEPTH - 1)) ?
                                      '0 : rptr_ff[best_idx_ff] + PW'(1);
               cnt_in[best_idx_ff]  = cnt_ff[best_idx_ff] - CW'(1);
               state_in      = ST_CHECK;
            end
         end

         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = STS_DONE;
               rsp_last_in   = 1'b1;
               cnt_in        = '0;
               rptr_in       = '0;
               ended_in      = '0;
               prev_in       = INT_MIN;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kind_ff       <= KIND_PUSH;
         cnt_ff        <= '0;
         rptr_ff       <= '0;
         ended_ff      <= '0;
         prev_ff       <= INT_MIN;
         scan_ff       <= '0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kind_ff       <= kind_in;
         cnt_ff        <= cnt_in;
         rptr_ff       <= rptr_in;
         ended_ff      <= ended_in;
         prev_ff       <= prev_in;
         scan_ff       <= scan_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   msm_ram #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // completion always closes the request's response train
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STS_DONE)) |-> rsp_tlast)
      else $error("completion response without tlast");

   // a scan must have found a nonempty run before emitting
   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best_found_ff)
      else $error("emit without a winning run");

   // completion clears the ended flags and resets the previous value
   a_fin_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && out_free) |=> ((ended_ff == '0) && (prev_ff == INT_MIN)))
      else $error("state not cleared after completion");

   // no element is popped from an empty run
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && out_free) |-> (cnt_ff[best_idx_ff] != '0))
      else $error("pop from empty run");

endmodule
